// File: rtl/labc_pkg.sv
// Shared types, constants and helper functions of the layer compositor.
`timescale 1ns / 1ps
`default_nettype none
package labc_pkg;

  // Canvas geometry: the store holds CANVAS_DIM x CANVAS_DIM RGB pixels
  localparam int CANVAS_DIM  = 256;
  localparam int COORD_W     = $clog2(CANVAS_DIM);
  localparam int ADDR_W      = 2 * COORD_W;
  localparam int STORE_DEPTH = CANVAS_DIM * CANVAS_DIM;

  // Field widths
  localparam int POS_W   = 12;   // col / row
  localparam int REG_W   = 13;   // widest config register
  localparam int DIM_W   = 9;    // canvas width / height registers
  localparam int MAP_W   = 15;   // signed mapped coordinate
  localparam int PIX_W   = 24;   // stored RGB
  localparam int PROD_W  = 16;   // one channel's blend sum
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;
  localparam int IN_DW   = 56;
  localparam int OUT_DW  = 32;

  // Item modes
  typedef logic [1:0] labc_mode_t;
  localparam labc_mode_t MODE_CLEAR = 2'd0;
  localparam labc_mode_t MODE_BLEND = 2'd1;
  localparam labc_mode_t MODE_READ  = 2'd2;

  // Register indexes (byte address = 4 * index)
  typedef logic [2:0] labc_reg_idx_t;
  localparam labc_reg_idx_t REG_CANVAS_X_MIN   = 3'd0;
  localparam labc_reg_idx_t REG_CANVAS_Y_MIN   = 3'd1;
  localparam labc_reg_idx_t REG_CANVAS_WIDTH   = 3'd2;
  localparam labc_reg_idx_t REG_CANVAS_HEIGHT  = 3'd3;
  localparam labc_reg_idx_t REG_LAYER_OFFSET_X = 3'd4;
  localparam labc_reg_idx_t REG_LAYER_OFFSET_Y = 3'd5;
  localparam labc_reg_idx_t REG_LAYER_WIDTH    = 3'd6;
  localparam labc_reg_idx_t REG_LAYER_HEIGHT   = 3'd7;

  localparam logic [DIM_W-1:0] CANVAS_DIM_RST = 9'd256;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [REG_W-1:0] canvas_x_min;
    logic [REG_W-1:0] canvas_y_min;
    logic [DIM_W-1:0] canvas_width;
    logic [DIM_W-1:0] canvas_height;
    logic [REG_W-1:0] layer_offset_x;
    logic [REG_W-1:0] layer_offset_y;
    logic [REG_W-1:0] layer_width;
    logic [REG_W-1:0] layer_height;
  } labc_cfg_t;

  // Mapped request leaving the address stage
  typedef struct packed {
    logic              valid;
    labc_mode_t        mode;
    logic              hit;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       src;
  } labc_req_t;

  // Exact floor(n / 255) for n up to 255*255
  function automatic logic [7:0] div255(input logic [PROD_W-1:0] n);
    logic [PROD_W:0] t;
    t = {1'b0, n} + {9'd0, n[PROD_W-1:8]} + 17'd1;
    return t[15:8];
  endfunction

  // dst*(255-a) + src*a for one channel
  function automatic logic [PROD_W-1:0] mix_sum(input logic [7:0] s, input logic [7:0] d,
                                                input logic [7:0] a);
    logic [PROD_W-1:0] p0;
    logic [PROD_W-1:0] p1;
    p0 = {8'd0, d} * {8'd0, 8'hff - a};
    p1 = {8'd0, s} * {8'd0, a};
    return p0 + p1;
  endfunction

endpackage
`default_nettype wire

// File: rtl/labc_cfg.sv
// APB-style configuration register file of the layer compositor.
`timescale 1ns / 1ps
`default_nettype none
module labc_cfg (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire  [labc_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire  [labc_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [labc_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready,
  output labc_pkg::labc_cfg_t          cfg_o
);
  import labc_pkg::*;

  labc_cfg_t     regs_r;
  labc_reg_idx_t idx;
  logic          wr_en;

  assign idx        = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_o      = regs_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '{canvas_x_min:   '0,
                  canvas_y_min:   '0,
                  canvas_width:   CANVAS_DIM_RST,
                  canvas_height:  CANVAS_DIM_RST,
                  layer_offset_x: '0,
                  layer_offset_y: '0,
                  layer_width:    '0,
                  layer_height:   '0};
    end else if (wr_en) begin
      unique case (idx)
        REG_CANVAS_X_MIN:   regs_r.canvas_x_min   <= cfg_pwdata[REG_W-1:0];
        REG_CANVAS_Y_MIN:   regs_r.canvas_y_min   <= cfg_pwdata[REG_W-1:0];
        REG_CANVAS_WIDTH:   regs_r.canvas_width   <= cfg_pwdata[DIM_W-1:0];
        REG_CANVAS_HEIGHT:  regs_r.canvas_height  <= cfg_pwdata[DIM_W-1:0];
        REG_LAYER_OFFSET_X: regs_r.layer_offset_x <= cfg_pwdata[REG_W-1:0];
        REG_LAYER_OFFSET_Y: regs_r.layer_offset_y <= cfg_pwdata[REG_W-1:0];
        REG_LAYER_WIDTH:    regs_r.layer_width    <= cfg_pwdata[REG_W-1:0];
        REG_LAYER_HEIGHT:   regs_r.layer_height   <= cfg_pwdata[REG_W-1:0];
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    unique case (idx)
      REG_CANVAS_X_MIN:   cfg_prdata = {19'd0, regs_r.canvas_x_min};
      REG_CANVAS_Y_MIN:   cfg_prdata = {19'd0, regs_r.canvas_y_min};
      REG_CANVAS_WIDTH:   cfg_prdata = {23'd0, regs_r.canvas_width};
      REG_CANVAS_HEIGHT:  cfg_prdata = {23'd0, regs_r.canvas_height};
      REG_LAYER_OFFSET_X: cfg_prdata = {19'd0, regs_r.layer_offset_x};
      REG_LAYER_OFFSET_Y: cfg_prdata = {19'd0, regs_r.layer_offset_y};
      REG_LAYER_WIDTH:    cfg_prdata = {19'd0, regs_r.layer_width};
      REG_LAYER_HEIGHT:   cfg_prdata = {19'd0, regs_r.layer_height};
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/labc_map.sv
// Input register and coordinate mapping / bounds check stage.
`timescale 1ns / 1ps
`default_nettype none
module labc_map (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           en,
  input  wire                           in_valid,
  input  wire  [1:0]                    in_mode,
  input  wire  [labc_pkg::POS_W-1:0]    in_col,
  input  wire  [labc_pkg::POS_W-1:0]    in_row,
  input  wire  [31:0]                   in_src,
  input  labc_pkg::labc_cfg_t           cfg_i,
  output labc_pkg::labc_req_t           req_o
);
  import labc_pkg::*;

  // Stage A: captured beat
  logic              a_valid_r;
  labc_mode_t        a_mode_r;
  logic [POS_W-1:0]  a_col_r;
  logic [POS_W-1:0]  a_row_r;
  logic [31:0]       a_src_r;

  // Stage B: mapped request
  logic              b_valid_r;
  labc_mode_t        b_mode_r;
  logic              b_hit_r;
  logic [ADDR_W-1:0] b_addr_r;
  logic [31:0]       b_src_r;

  logic [REG_W-1:0]  cw_eff;
  logic [REG_W-1:0]  ch_eff;
  logic [MAP_W-1:0]  bx;
  logic [MAP_W-1:0]  by;
  logic [MAP_W-1:0]  x;
  logic [MAP_W-1:0]  y;
  logic              in_layer;
  logic              hit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mode_r <= in_mode;
      a_col_r  <= in_col;
      a_row_r  <= in_row;
      a_src_r  <= in_src;
      b_mode_r <= a_mode_r;
      b_hit_r  <= hit_nxt;
      b_addr_r <= {y[COORD_W-1:0], x[COORD_W-1:0]};
      b_src_r  <= a_src_r;
    end
  end

  // Effective canvas size, saturated to the store dimension
  always_comb begin
    cw_eff = ({4'd0, cfg_i.canvas_width} > REG_W'(CANVAS_DIM)) ?
             REG_W'(CANVAS_DIM) : {4'd0, cfg_i.canvas_width};
    ch_eff = ({4'd0, cfg_i.canvas_height} > REG_W'(CANVAS_DIM)) ?
             REG_W'(CANVAS_DIM) : {4'd0, cfg_i.canvas_height};
  end

  // Layer to canvas mapping for blends: pos + layer_offset - canvas_min
  always_comb begin
    bx = {3'd0, a_col_r}
       + {{2{cfg_i.layer_offset_x[REG_W-1]}}, cfg_i.layer_offset_x}
       - {{2{cfg_i.canvas_x_min[REG_W-1]}}, cfg_i.canvas_x_min};
    by = {3'd0, a_row_r}
       + {{2{cfg_i.layer_offset_y[REG_W-1]}}, cfg_i.layer_offset_y}
       - {{2{cfg_i.canvas_y_min[REG_W-1]}}, cfg_i.canvas_y_min};
    in_layer = ({1'b0, a_col_r} < cfg_i.layer_width) &&
               ({1'b0, a_row_r} < cfg_i.layer_height);
    if (a_mode_r == MODE_BLEND) begin
      x = bx;
      y = by;
    end else begin
      x = {3'd0, a_col_r};
      y = {3'd0, a_row_r};
    end
    hit_nxt = (a_mode_r == MODE_CLEAR || a_mode_r == MODE_READ ||
               (a_mode_r == MODE_BLEND && in_layer)) &&
              !x[MAP_W-1] && !y[MAP_W-1] &&
              (x[MAP_W-2:0] < {1'b0, cw_eff}) &&
              (y[MAP_W-2:0] < {1'b0, ch_eff});
  end

  assign req_o = '{valid: b_valid_r, mode: b_mode_r, hit: b_hit_r,
                   addr: b_addr_r, src: b_src_r};

endmodule
`default_nettype wire

// File: rtl/labc_canvas.sv
// Canvas store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module labc_canvas (
  input  wire                           clk,
  input  wire                           rd_en,
  input  wire  [labc_pkg::ADDR_W-1:0]   rd_addr,
  output logic [labc_pkg::PIX_W-1:0]    rd_data,
  input  wire                           wr_en,
  input  wire  [labc_pkg::ADDR_W-1:0]   wr_addr,
  input  wire  [labc_pkg::PIX_W-1:0]    wr_data
);
  import labc_pkg::*;

  logic [PIX_W-1:0] mem [STORE_DEPTH];
  logic [PIX_W-1:0] rd_data_r;

  // Read returns the contents before a same-edge write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: rtl/layer_alpha_blend_compositor_top.sv
// Top level of the layer alpha-blend compositor.
//
// Input beats (in_*) carry a mode in in_tuser and col, row and a layer pixel
// in in_tdata. Clear writes opaque black at a canvas position, blend maps a
// layer pixel onto the canvas and mixes it source-over, read returns a canvas
// pixel. Every input beat gives exactly one output beat: out_tdata holds the
// read pixel (alpha 0xff) or zero, out_tuser flags a dropped beat.
// The user must set geometry over the cfg_* port while the block is idle;
// the block does not enforce this. Pipeline: input register, map/bounds
// check, canvas read, channel multiply, divide-by-255 and canvas write,
// output register. One beat per cycle is sustained while the receiver
// takes beats. Back-to-back hits on one pixel are forwarded from the two
// stages after the canvas read, so they do not stall the pipeline.
// Reset empties the pipeline and restores the register defaults; the canvas
// is not cleared, so a pixel must be cleared or blended before it is read.
// The whole pipeline holds, and in_tready drops, only while the output
// register holds a beat that the receiver has not taken.
`timescale 1ns / 1ps
`default_nettype none
module layer_alpha_blend_compositor_top (
  input  wire                          clk,
  input  wire                          rst_n,
  // in_tdata: col[11:0], row[23:12], src_pixel[55:24]
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [labc_pkg::IN_DW-1:0]   in_tdata,
  // in_tuser: mode[1:0]
  input  wire  [1:0]                   in_tuser,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  // out_tdata: canvas_pixel[31:0]
  output logic [labc_pkg::OUT_DW-1:0]  out_tdata,
  // out_tuser: dropped[0]
  output logic                         out_tuser,
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire  [labc_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire  [labc_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [labc_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import labc_pkg::*;

  labc_cfg_t         cfg;
  labc_req_t         req;
  logic              en;
  logic [PIX_W-1:0]  rd_data;

  // Stage C: canvas data ready, multiply
  logic              c_valid_r;
  labc_mode_t        c_mode_r;
  logic              c_hit_r;
  logic [ADDR_W-1:0] c_addr_r;
  logic [31:0]       c_src_r;

  // Stage D: divide and write
  logic              d_valid_r;
  labc_mode_t        d_mode_r;
  logic              d_hit_r;
  logic [ADDR_W-1:0] d_addr_r;
  logic [PROD_W-1:0] d_sum_r [3];

  // Stage E: output register, also last forwarding source
  logic              e_valid_r;
  logic              e_hit_r;
  logic              e_rd_r;
  logic              e_wr_r;
  logic [ADDR_W-1:0] e_addr_r;
  logic [PIX_W-1:0]  e_pix_r;

  logic [PIX_W-1:0]  dst;
  logic [7:0]        alpha;
  logic [PIX_W-1:0]  d_pix;
  logic              d_wr;

  assign en        = !e_valid_r || out_tready;
  assign in_tready = en;

  labc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  labc_map u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_mode  (in_tuser),
    .in_col   (in_tdata[11:0]),
    .in_row   (in_tdata[23:12]),
    .in_src   (in_tdata[55:24]),
    .cfg_i    (cfg),
    .req_o    (req)
  );

  labc_canvas u_canvas (
    .clk     (clk),
    .rd_en   (en),
    .rd_addr (req.addr),
    .rd_data (rd_data),
    .wr_en   (en && d_wr),
    .wr_addr (d_addr_r),
    .wr_data (d_pix)
  );

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
      e_wr_r    <= 1'b0;
    end else if (en) begin
      c_valid_r <= req.valid;
      d_valid_r <= c_valid_r;
      e_valid_r <= d_valid_r;
      e_wr_r    <= d_wr;
    end
  end

  // Forward pending writes: the stage D beat has not written yet, the
  // stage E beat wrote at the same edge as the canvas read
  always_comb begin
    priority if (d_wr && d_addr_r == c_addr_r) begin
      dst = d_pix;
    end else if (e_wr_r && e_addr_r == c_addr_r) begin
      dst = e_pix_r;
    end else begin
      dst = rd_data;
    end
    // a read passes dst through as dst*255/255
    alpha = (c_mode_r == MODE_BLEND) ? c_src_r[31:24] : 8'd0;
  end

  // Divide by 255; clears write black
  always_comb begin
    if (d_mode_r == MODE_CLEAR) begin
      d_pix = '0;
    end else begin
      d_pix = {div255(d_sum_r[2]), div255(d_sum_r[1]), div255(d_sum_r[0])};
    end
    d_wr = d_valid_r && d_hit_r && (d_mode_r == MODE_CLEAR || d_mode_r == MODE_BLEND);
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      c_mode_r   <= req.mode;
      c_hit_r    <= req.hit;
      c_addr_r   <= req.addr;
      c_src_r    <= req.src;
      d_mode_r   <= c_mode_r;
      d_hit_r    <= c_hit_r;
      d_addr_r   <= c_addr_r;
      d_sum_r[0] <= mix_sum(c_src_r[7:0], dst[7:0], alpha);
      d_sum_r[1] <= mix_sum(c_src_r[15:8], dst[15:8], alpha);
      d_sum_r[2] <= mix_sum(c_src_r[23:16], dst[23:16], alpha);
      e_hit_r    <= d_hit_r;
      e_rd_r     <= d_hit_r && (d_mode_r == MODE_READ);
      e_addr_r   <= d_addr_r;
      e_pix_r    <= d_pix;
    end
  end

  assign out_tvalid = e_valid_r;
  assign out_tdata  = e_rd_r ? {8'hff, e_pix_r} : '0;
  assign out_tuser  = !e_hit_r;

  // Output pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // A dropped beat carries no pixel
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("dropped beat with nonzero pixel");

  // Any nonzero result is an opaque read pixel
  a_read_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata != '0 |-> out_tdata[31:24] == 8'hff && !out_tuser)
    else $error("read pixel without opaque alpha");

  // A stall freezes the divide and write stage
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en && d_valid_r |=> $stable(d_addr_r) && $stable(d_hit_r) && d_valid_r)
    else $error("pipeline moved during stall");

  // Canvas writes only come from hitting beats
  a_write_hit: assert property (@(posedge clk) disable iff (!rst_n)
    d_wr |-> d_valid_r && d_hit_r && d_mode_r != MODE_READ)
    else $error("canvas write from a dropped or read beat");

endmodule
`default_nettype wire
